[rtl/zsma_pkg.sv]
// Shared types and constants for the zero-skipping moving average core.
// No dependencies; imported by every module of the block except zsma_ram.
`default_nettype none

package zsma_pkg;

    // Fixed field widths of the sample, average and used-count ports
    localparam int SAMPLE_W = 16;
    localparam int USED_W   = 4;
    localparam int USED_MAX = 15;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // latch the incoming samples, read the ring slot
        logic update;    // replace the ring slot, adjust totals and counts
        logic load_div;  // load both dividers from the new totals
        logic step;      // one restoring division step in both dividers
        logic load_out;  // move the quotients into the output register
    } t_cmd;

endpackage

`default_nettype wire

[rtl/zsma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module zsma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write on enable, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/zsma_div.sv]
// Restoring serial divider: signed total by unsigned count, one quotient bit a step.
// Depends on zsma_pkg for the result width.
`default_nettype none

module zsma_div #(
    parameter int NUM_W = 19,
    parameter int DEN_W = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire logic                          i_step,
    input  wire logic signed [NUM_W-1:0]       i_num,
    input  wire logic        [DEN_W-1:0]       i_den,
    output logic signed [zsma_pkg::SAMPLE_W-1:0] o_quot
);
    import zsma_pkg::*;

    logic             r_neg;
    logic             r_zero;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;

    logic [NUM_W-1:0]    num_mag;
    logic [DEN_W:0]      shifted;
    logic [DEN_W:0]      diff;
    logic                fits;
    logic [SAMPLE_W-1:0] mag16;

    // Magnitude of the dividend and the trial subtraction
    always_comb begin
        num_mag = i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;
        shifted = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = shifted >= {1'b0, r_den};
        mag16   = r_quo[SAMPLE_W-1:0];
    end

    // Load operands, then shift one quotient bit in per step
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg  <= i_num[NUM_W-1];
            r_zero <= (i_den == '0);
            r_quo  <= num_mag;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (i_step) begin
            r_rem <= fits ? diff : shifted;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    // Apply sign; an empty window gives zero
    always_comb begin
        if (r_zero) begin
            o_quot = '0;
        end else if (r_neg) begin
            o_quot = signed'(~mag16 + SAMPLE_W'(1));
        end else begin
            o_quot = signed'(mag16);
        end
    end

endmodule

`default_nettype wire

[rtl/zsma_dp.sv]
// Datapath: ring memory, write position, running totals and counts, dividers, output register.
// Depends on zsma_pkg, zsma_ram and zsma_div.
`default_nettype none

module zsma_dp #(
    parameter int WINDOW = 8,
    parameter int POS_W  = 3,
    parameter int CNT_W  = 4,
    parameter int TOT_W  = 19
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire zsma_pkg::t_cmd                        i_cmd,
    input  wire logic signed [zsma_pkg::SAMPLE_W-1:0]  i_t_samp,
    input  wire logic signed [zsma_pkg::SAMPLE_W-1:0]  i_h_samp,
    output logic signed [zsma_pkg::SAMPLE_W-1:0]       o_t_avg,
    output logic signed [zsma_pkg::SAMPLE_W-1:0]       o_h_avg,
    output logic        [zsma_pkg::USED_W-1:0]         o_t_used,
    output logic        [zsma_pkg::USED_W-1:0]         o_h_used
);
    import zsma_pkg::*;

    logic [POS_W-1:0]          r_pos;
    logic [WINDOW-1:0]         r_vld;
    logic signed [SAMPLE_W-1:0] r_t_samp;
    logic signed [SAMPLE_W-1:0] r_h_samp;
    logic signed [TOT_W-1:0]   r_t_tot;
    logic signed [TOT_W-1:0]   r_h_tot;
    logic [CNT_W-1:0]          r_t_cnt;
    logic [CNT_W-1:0]          r_h_cnt;

    logic [2*SAMPLE_W-1:0]      rdata;
    logic signed [SAMPLE_W-1:0] t_old;
    logic signed [SAMPLE_W-1:0] h_old;
    logic signed [TOT_W-1:0]    n_t_tot;
    logic signed [TOT_W-1:0]    n_h_tot;
    logic [CNT_W-1:0]           n_t_cnt;
    logic [CNT_W-1:0]           n_h_cnt;
    logic [POS_W-1:0]           n_pos;
    logic signed [SAMPLE_W-1:0] t_quot;
    logic signed [SAMPLE_W-1:0] h_quot;

    // Both rings share one address, so they share one memory word
    zsma_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_pos),
        .i_wdata ({r_t_samp, r_h_samp}),
        .i_raddr (r_pos),
        .o_rdata (rdata)
    );

    // Old entries read as zero until their slot is first written
    always_comb begin
        t_old   = r_vld[r_pos] ? signed'(rdata[2*SAMPLE_W-1:SAMPLE_W]) : '0;
        h_old   = r_vld[r_pos] ? signed'(rdata[SAMPLE_W-1:0]) : '0;
        n_t_tot = r_t_tot - TOT_W'(t_old) + TOT_W'(r_t_samp);
        n_h_tot = r_h_tot - TOT_W'(h_old) + TOT_W'(r_h_samp);
        n_t_cnt = r_t_cnt - CNT_W'(t_old != '0) + CNT_W'(r_t_samp != '0);
        n_h_cnt = r_h_cnt - CNT_W'(h_old != '0) + CNT_W'(r_h_samp != '0);
        n_pos   = (r_pos == POS_W'(WINDOW - 1)) ? '0 : r_pos + POS_W'(1);
    end

    // Hold running state; clear on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_vld   <= '0;
            r_t_tot <= '0;
            r_h_tot <= '0;
            r_t_cnt <= '0;
            r_h_cnt <= '0;
        end else if (i_cmd.update) begin
            r_pos        <= n_pos;
            r_vld[r_pos] <= 1'b1;
            r_t_tot      <= n_t_tot;
            r_h_tot      <= n_h_tot;
            r_t_cnt      <= n_t_cnt;
            r_h_cnt      <= n_h_cnt;
        end
    end

    // Capture the samples of the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_t_samp <= i_t_samp;
            r_h_samp <= i_h_samp;
        end
    end

    zsma_div #(
        .NUM_W (TOT_W),
        .DEN_W (CNT_W)
    ) u_t_div (
        .i_clk  (i_clk),
        .i_load (i_cmd.load_div),
        .i_step (i_cmd.step),
        .i_num  (r_t_tot),
        .i_den  (r_t_cnt),
        .o_quot (t_quot)
    );

    zsma_div #(
        .NUM_W (TOT_W),
        .DEN_W (CNT_W)
    ) u_h_div (
        .i_clk  (i_clk),
        .i_load (i_cmd.load_div),
        .i_step (i_cmd.step),
        .i_num  (r_h_tot),
        .i_den  (r_h_cnt),
        .o_quot (h_quot)
    );

    // Load the output register; used counts saturate at the field limit
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_t_avg  <= t_quot;
            o_h_avg  <= h_quot;
            o_t_used <= (32'(r_t_cnt) > 32'(USED_MAX)) ? USED_W'(USED_MAX) : USED_W'(r_t_cnt);
            o_h_used <= (32'(r_h_cnt) > 32'(USED_MAX)) ? USED_W'(USED_MAX) : USED_W'(r_h_cnt);
        end
    end

endmodule

`default_nettype wire

[rtl/zsma_ctrl.sv]
// Controller: sequences accept, ring update, divider load and steps, result hand-off.
// Depends on zsma_pkg for the command struct.
`default_nettype none

module zsma_ctrl #(
    parameter int TOT_W = 19
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_stall,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output zsma_pkg::t_cmd      o_cmd
);
    import zsma_pkg::*;

    localparam int STEP_W = $clog2(TOT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LOAD,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              n_out_valid;
    logic              out_free;

    // Decode commands and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_step      = r_step;
        out_free    = !o_out_valid || !i_out_stall;
        n_out_valid = o_out_valid && i_out_stall;
        o_in_stall  = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_LOAD;
            end
            ST_LOAD: begin
                o_cmd.load_div = 1'b1;
                n_step         = '0;
                n_state        = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                o_cmd.step = 1'b1;
                n_step     = r_step + STEP_W'(1);
                if (r_step == STEP_W'(TOT_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state, step count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            o_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[rtl/zero_skipping_moving_average_core.sv]
// Top level of the zero-skipping moving average core: controller plus datapath.
// Depends on zsma_pkg, zsma_ctrl and zsma_dp.
//
//   channel  | valid   | stall   | payload
//   ---------+---------+---------+----------------------------------------------
//   input    | i_valid | o_stall | i_temperature_sample, i_humidity_sample
//   output   | o_valid | i_stall | o_temperature_average, o_humidity_average,
//            |         |         | o_temperature_used, o_humidity_used
//
// A transaction runs accept, ring update, divider load, division steps and result hand-off in turn;
// the restoring dividers produce one quotient bit per cycle.
// A finished result sits in the output register while the next transaction is taken;
// the block only waits in its final state if that register is still stalled.
// Synchronous active-low reset empties both rings (per-slot valid flags), zeroes
// totals, counts and write position, and drops o_valid. No clearing pass is needed.
`default_nettype none

module zero_skipping_moving_average_core #(
    parameter int WINDOW = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [zsma_pkg::SAMPLE_W-1:0] i_temperature_sample,
    input  wire logic signed [zsma_pkg::SAMPLE_W-1:0] i_humidity_sample,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [zsma_pkg::SAMPLE_W-1:0]      o_temperature_average,
    output logic signed [zsma_pkg::SAMPLE_W-1:0]      o_humidity_average,
    output logic        [zsma_pkg::USED_W-1:0]        o_temperature_used,
    output logic        [zsma_pkg::USED_W-1:0]        o_humidity_used
);
    import zsma_pkg::*;

    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int TOT_W = SAMPLE_W + $clog2(WINDOW);

    t_cmd cmd;

    zsma_ctrl #(
        .TOT_W (TOT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_stall (i_stall),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    zsma_dp #(
        .WINDOW (WINDOW),
        .POS_W  (POS_W),
        .CNT_W  (CNT_W),
        .TOT_W  (TOT_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_t_samp (i_temperature_sample),
        .i_h_samp (i_humidity_sample),
        .o_t_avg  (o_temperature_average),
        .o_h_avg  (o_humidity_average),
        .o_t_used (o_temperature_used),
        .o_h_used (o_humidity_used)
    );

endmodule

`default_nettype wire

[rtl/zsma_chk.sv]
// Port-level checker for the zero-skipping moving average core, bound to the top level.
// Depends on zsma_pkg and zero_skipping_moving_average_core.
`default_nettype none

module zsma_chk #(
    parameter int WINDOW = 8
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_valid,
    input wire logic                                 o_stall,
    input wire logic signed [zsma_pkg::SAMPLE_W-1:0] i_temperature_sample,
    input wire logic signed [zsma_pkg::SAMPLE_W-1:0] i_humidity_sample,
    input wire logic                                 o_valid,
    input wire logic                                 i_stall,
    input wire logic signed [zsma_pkg::SAMPLE_W-1:0] o_temperature_average,
    input wire logic signed [zsma_pkg::SAMPLE_W-1:0] o_humidity_average,
    input wire logic        [zsma_pkg::USED_W-1:0]   o_temperature_used,
    input wire logic        [zsma_pkg::USED_W-1:0]   o_humidity_used
);
    import zsma_pkg::*;

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temperature_average)
            && $stable(o_humidity_average) && $stable(o_temperature_used)
            && $stable(o_humidity_used))
        else $error("stalled result changed");

    // One transaction at a time: stall follows every accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted while busy");

    // Used counts never exceed the window
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_temperature_used) <= WINDOW
            && 32'(o_humidity_used) <= WINDOW)
        else $error("used count exceeds window");

    // An empty window averages to zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_temperature_used == '0 && o_humidity_used == '0
            |-> o_temperature_average == '0 && o_humidity_average == '0)
        else $error("nonzero average with no entries");

endmodule

bind zero_skipping_moving_average_core zsma_chk #(.WINDOW(WINDOW)) u_zsma_chk (.*);

`default_nettype wire
